[design/anp_pkg.sv]
// ============================================================================
// anp_pkg
// Shared types and character constants for the ASCII number parser.
// ============================================================================
package anp_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_ZERO = 8'h30;   // '0'
    localparam logic [7:0] CH_NINE = 8'h39;   // '9'
    localparam logic [7:0] CH_LC_A = 8'h61;   // 'a'
    localparam logic [7:0] CH_LC_F = 8'h66;   // 'f'
    localparam logic [7:0] CH_UC_A = 8'h41;   // 'A'
    localparam logic [7:0] CH_UC_F = 8'h46;   // 'F'
    localparam logic [7:0] CH_LC_X = 8'h78;   // 'x'
    localparam logic [7:0] LC_BIAS = 8'h57;   // 'a' - 10
    localparam logic [7:0] UC_BIAS = 8'h37;   // 'A' - 10

    // Radix
    localparam int unsigned DECIMAL = 10;
    localparam int unsigned HEX     = 16;

    // Parse state, one-hot
    typedef enum logic [4:0] {
        MODE_START = 5'b00001,
        MODE_ZERO  = 5'b00010,
        MODE_DEC   = 5'b00100,
        MODE_HEX   = 5'b01000,
        MODE_SKIP  = 5'b10000
    } t_mode;

    // Control out of the step logic
    typedef struct packed {
        logic  emit;
        t_mode next_mode;
    } t_step_ctl;

endpackage

[design/ascii_number_parser.sv]
// ============================================================================
// ascii_number_parser
// Stream converter from NUL-terminated ASCII decimal or 0x-hex strings
// to unsigned numbers with a count of consumed bytes.
// ============================================================================
// Usage:
//   Slave channel s_axis carries one character per beat in tdata[7:0].
//   Master channel m_axis carries one result per finished number:
//   value in the low VALUE_WIDTH bits, end_offset above it.
//   A string ends on NUL or on the first byte that is not a digit of its
//   radix; after a non-digit end the rest up to NUL is dropped silently.
// Timing:
//   One character per cycle, sustained while no result blocks. A character sits
//   in the input register while the step logic works on it against the parse
//   state; the result of an ending character is loaded into the result register,
//   which drives m_axis.
// Reset:
//   Synchronous, active low. Clears both valid flags and returns the parse
//   state to the start of a string with a zero accumulator and count.
// Backpressure:
//   The output register holds a result until m_axis_tready. Characters that
//   produce no result keep flowing while a result waits; a character that
//   ends a number holds in the input register until the output frees.
// ============================================================================
module ascii_number_parser
    import anp_pkg::*;
#(
    parameter int VALUE_WIDTH  = 32,
    parameter int OFFSET_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // s_axis_tdata: [7:0] char_in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,
    // m_axis_tdata: [VALUE_WIDTH-1:0] value, then end_offset, zero padded
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [((VALUE_WIDTH+OFFSET_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    localparam int TDATA_W = ((VALUE_WIDTH + OFFSET_WIDTH + 7) / 8) * 8;

    // Input register
    logic                    r_in_valid;
    logic [7:0]              r_in_char;

    // Parse state
    t_mode                   r_mode;
    logic [VALUE_WIDTH-1:0]  r_acc;
    logic [OFFSET_WIDTH-1:0] r_cnt;

    // Result register
    logic                    r_out_valid;
    logic [VALUE_WIDTH-1:0]  r_out_value;
    logic [OFFSET_WIDTH-1:0] r_out_offset;

    // Step logic outputs
    t_step_ctl               step_ctl;
    logic [VALUE_WIDTH-1:0]  n_acc;
    logic [OFFSET_WIDTH-1:0] n_cnt;
    logic [VALUE_WIDTH-1:0]  res_value;
    logic [OFFSET_WIDTH-1:0] res_offset;

    logic                    out_free;
    logic                    advance;

    anp_step #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_step (
        .i_mode       (r_mode),
        .i_acc        (r_acc),
        .i_cnt        (r_cnt),
        .i_char       (r_in_char),
        .o_ctl        (step_ctl),
        .o_next_acc   (n_acc),
        .o_next_cnt   (n_cnt),
        .o_res_value  (res_value),
        .o_res_offset (res_offset)
    );

    // Output slot is free if empty or being drained this cycle
    assign out_free = !r_out_valid || m_axis_tready;
    // Consume the held character unless it emits into a blocked output
    assign advance  = r_in_valid && (!step_ctl.emit || out_free);

    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'({r_out_offset, r_out_value});

    // Input register: take a beat whenever it is empty or the held one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready) begin
            r_in_char <= s_axis_tdata;
        end
    end

    // Parse state: advance once per consumed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
            r_acc  <= '0;
            r_cnt  <= '0;
        end else if (advance) begin
            r_mode <= step_ctl.next_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
        end
    end

    // Result register: load on an emitting step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && step_ctl.emit) begin
            r_out_value  <= res_value;
            r_out_offset <= res_offset;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && step_ctl.emit) |=> (r_acc == '0 && r_cnt == '0))
        else $error("parse state not cleared after a result");

    a_skip_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_SKIP) |-> (r_acc == '0 && r_cnt == '0))
        else $error("nonzero accumulator while dropping a tail");

    a_zero_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ZERO) |-> (r_acc == '0 && r_cnt == OFFSET_WIDTH'(1)))
        else $error("leading-zero state holds a wrong count");

    a_cnt_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !step_ctl.emit && r_cnt == '1 && r_mode != MODE_SKIP)
        |=> (r_cnt == '1))
        else $error("byte count wrapped");

    a_stall_only_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && step_ctl.emit && r_out_valid))
        else $error("input stalled without a blocked result");

endmodule

[design/anp_step.sv]
// ============================================================================
// anp_step
// Next-state and result logic for one character of the string.
// ============================================================================
module anp_step
    import anp_pkg::*;
#(
    parameter int VALUE_WIDTH  = 32,
    parameter int OFFSET_WIDTH = 16
) (
    input  t_mode                    i_mode,
    input  logic [VALUE_WIDTH-1:0]   i_acc,
    input  logic [OFFSET_WIDTH-1:0]  i_cnt,
    input  logic [7:0]               i_char,
    output t_step_ctl                o_ctl,
    output logic [VALUE_WIDTH-1:0]   o_next_acc,
    output logic [OFFSET_WIDTH-1:0]  o_next_cnt,
    output logic [VALUE_WIDTH-1:0]   o_res_value,
    output logic [OFFSET_WIDTH-1:0]  o_res_offset
);

    logic                    is_dec;
    logic                    is_lc;
    logic                    is_uc;
    logic [7:0]              digit8;
    logic [VALUE_WIDTH-1:0]  digit;
    logic [OFFSET_WIDTH-1:0] cnt_inc;
    logic [VALUE_WIDTH-1:0]  acc_dec;
    logic [VALUE_WIDTH-1:0]  acc_hex;

    always_comb begin
        is_dec = i_char inside {[CH_ZERO:CH_NINE]};
        is_lc  = i_char inside {[CH_LC_A:CH_LC_F]};
        is_uc  = i_char inside {[CH_UC_A:CH_UC_F]};
        if (is_lc) begin
            digit8 = i_char - LC_BIAS;
        end else if (is_uc) begin
            digit8 = i_char - UC_BIAS;
        end else begin
            digit8 = i_char - CH_ZERO;
        end
        digit   = VALUE_WIDTH'(digit8[3:0]);
        cnt_inc = (i_cnt == '1) ? i_cnt : i_cnt + OFFSET_WIDTH'(1);
        acc_dec = i_acc * VALUE_WIDTH'(DECIMAL) + digit;
        acc_hex = (i_acc << $clog2(HEX)) + digit;
    end

    always_comb begin
        o_ctl.emit      = 1'b0;
        o_ctl.next_mode = i_mode;
        o_next_acc      = i_acc;
        o_next_cnt      = i_cnt;
        o_res_value     = i_acc;
        o_res_offset    = i_cnt;

        case (i_mode)
            MODE_SKIP: begin
                if (i_char == CH_NUL) begin
                    o_ctl.next_mode = MODE_START;
                end
            end
            MODE_ZERO: begin
                if (i_char == CH_LC_X) begin
                    o_next_cnt      = cnt_inc;
                    o_ctl.next_mode = MODE_HEX;
                end else if (i_char == CH_NUL) begin
                    o_ctl.emit      = 1'b1;
                    o_ctl.next_mode = MODE_START;
                end else if (is_dec) begin
                    o_next_acc      = digit;
                    o_next_cnt      = cnt_inc;
                    o_ctl.next_mode = MODE_DEC;
                end else begin
                    o_ctl.emit      = 1'b1;
                    o_ctl.next_mode = MODE_SKIP;
                end
            end
            MODE_DEC, MODE_HEX: begin
                if (i_char == CH_NUL) begin
                    o_ctl.emit      = 1'b1;
                    o_ctl.next_mode = MODE_START;
                end else if (is_dec || (i_mode == MODE_HEX && (is_lc || is_uc))) begin
                    o_next_acc = (i_mode == MODE_HEX) ? acc_hex : acc_dec;
                    o_next_cnt = cnt_inc;
                end else begin
                    o_ctl.emit      = 1'b1;
                    o_ctl.next_mode = MODE_SKIP;
                end
            end
            default: begin
                // start of string; unused codes land here too
                o_res_value  = '0;
                o_res_offset = '0;
                o_next_acc   = '0;
                o_next_cnt   = '0;
                if (i_char == CH_NUL) begin
                    o_ctl.emit      = 1'b1;
                    o_ctl.next_mode = MODE_START;
                end else if (i_char == CH_ZERO) begin
                    o_next_cnt      = OFFSET_WIDTH'(1);
                    o_ctl.next_mode = MODE_ZERO;
                end else if (is_dec) begin
                    o_next_acc      = digit;
                    o_next_cnt      = OFFSET_WIDTH'(1);
                    o_ctl.next_mode = MODE_DEC;
                end else begin
                    o_ctl.emit      = 1'b1;
                    o_ctl.next_mode = MODE_SKIP;
                end
            end
        endcase

        // Clear the running number whenever a result leaves
        if (o_ctl.emit) begin
            o_next_acc = '0;
            o_next_cnt = '0;
        end
    end

endmodule
